@@ src/bkj_pkg.sv @@
// Shared types, constants and register map of the backoff engine.
package bkj_pkg;

  localparam int DELAY_W  = 22;
  localparam int GROWTH_W = 10;
  localparam int JITTER_W = 7;
  localparam int COUNT_W  = 32;
  localparam int SEED_W   = 32;
  localparam int OP_W     = 2;
  localparam int SPAN_W   = JITTER_W + 1;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // floor(x / 100) for any 32-bit x is (x * DIV100_RECIP) >> DIV100_SHIFT.
  localparam logic [MUL_W-1:0] DIV100_RECIP = 32'd1374389535;
  localparam int               DIV100_SHIFT = 37;

  localparam logic [DELAY_W-1:0]  INITIAL_RST = 22'd1000;
  localparam logic [DELAY_W-1:0]  MAX_RST     = 22'd30000;
  localparam logic [GROWTH_W-1:0] GROWTH_RST  = 10'd200;
  localparam logic [JITTER_W-1:0] JITTER_RST  = 7'd10;
  localparam logic [COUNT_W-1:0]  LIMIT_RST   = 32'd0;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY     = 2'd0,
    OP_FAILURE   = 2'd1,
    OP_SUCCESS   = 2'd2,
    OP_RECOMPUTE = 2'd3
  } op_t;

  // Register index, taken from paddr[4:2].
  localparam logic [2:0] REG_INITIAL = 3'd0;
  localparam logic [2:0] REG_MAX     = 3'd1;
  localparam logic [2:0] REG_GROWTH  = 3'd2;
  localparam logic [2:0] REG_JITTER  = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_CHK    = 10'b00_0000_0010,
    ST_GROW   = 10'b00_0000_0100,
    ST_SCALE  = 10'b00_0000_1000,
    ST_NEXT   = 10'b00_0001_0000,
    ST_JSTART = 10'b00_0010_0000,
    ST_JMOD   = 10'b00_0100_0000,
    ST_JMUL   = 10'b00_1000_0000,
    ST_JDIV   = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_t;

endpackage

@@ src/bkj_mul.sv @@
// Shared 32 by 32 multiplier with a registered product.
module bkj_mul (
  input  logic                      clk,
  input  logic [bkj_pkg::MUL_W-1:0]  a,
  input  logic [bkj_pkg::MUL_W-1:0]  b,
  output logic [bkj_pkg::PROD_W-1:0] p_r
);
  import bkj_pkg::*;

  logic [PROD_W-1:0] p_nxt;

  assign p_nxt = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

@@ src/bkj_rem.sv @@
// Bit-serial restoring remainder of a 32-bit word by an 8-bit divisor.
module bkj_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bkj_pkg::SEED_W-1:0] dividend,
  input  logic [bkj_pkg::SPAN_W-1:0] divisor,
  output logic                       done_r,
  output logic [bkj_pkg::SPAN_W-1:0] rem_r
);
  import bkj_pkg::*;

  localparam int CNT_W = $clog2(SEED_W);

  logic              busy_r, busy_nxt;
  logic              done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SEED_W-1:0] word_r, word_nxt;
  logic [SPAN_W-1:0] div_r, div_nxt;
  logic [SPAN_W-1:0] rem_nxt;
  logic [SPAN_W:0]   trial;

  assign trial = {rem_r, word_r[SEED_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      word_nxt = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so one subtract suffices.
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SPAN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[SPAN_W-1:0];
      end
      word_nxt = {word_r[SEED_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SEED_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    word_r <= word_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

@@ src/exponential_backoff_with_jitter.sv @@
// Top level of the reconnect backoff engine: registers, sequencer and result stage.
//
// Each input transfer (tuser = opcode, tdata = seed) yields exactly one result
// transfer. For a query, the jitter offset comes from a bit-serial remainder
// unit, followed by two passes through the shared multiplier; with jitter
// disabled both are skipped. Failure, success and recompute first rebuild the
// base delay; every growth step makes two passes through the shared multiplier
// (one multiply for the clamp test, one reciprocal multiply for the divide by
// 100), and the number of steps is the retry count or fewer, because the walk
// ends at the clamp or once the delay stops changing (at most about 1200 steps
// for any register setting). The block takes one item at a time; in_tready
// rises in the cycle the result becomes valid, and a finished result waits in
// the output register while the next item is accepted.
module exponential_backoff_with_jitter (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [21:0] backoff_ms, [43:22] jittered_delay,
                                  // [44] retry_denied, [47:45] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bkj_pkg::*;

  // Configuration registers.
  logic [DELAY_W-1:0]  initial_r;
  logic [DELAY_W-1:0]  max_r;
  logic [GROWTH_W-1:0] growth_r;
  logic [JITTER_W-1:0] jitter_r;
  logic [COUNT_W-1:0]  limit_r;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  // Engine state.
  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [DELAY_W-1:0]  cur_r, cur_nxt;
  logic [DELAY_W-1:0]  d_r, d_nxt;
  logic [COUNT_W-1:0]  step_r, step_nxt;
  logic [MUL_W-1:0]    dg_r, dg_nxt;
  logic [SEED_W-1:0]   seed_r, seed_nxt;
  logic [DELAY_W-1:0]  jit_r, jit_nxt;

  // Result register.
  logic                ovalid_r, ovalid_nxt;
  logic [DELAY_W-1:0]  obase_r, obase_nxt;
  logic [DELAY_W-1:0]  ojit_r, ojit_nxt;
  logic                odeny_r, odeny_nxt;

  // Shared units.
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic                rem_start;
  logic                rem_done;
  logic [SPAN_W-1:0]   rem_val;
  logic [SEED_W-1:0]   hash;
  logic [SPAN_W-1:0]   span;

  logic                in_xfer;
  logic [28:0]         max_x100;
  logic [26:0]         quot;
  logic [SPAN_W+1:0]   fsum;
  logic [SPAN_W-1:0]   factor;
  logic                factor_pos;

  // ---------------------------------------------------------------- config
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_r <= INITIAL_RST;
      max_r     <= MAX_RST;
      growth_r  <= GROWTH_RST;
      jitter_r  <= JITTER_RST;
      limit_r   <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INITIAL: initial_r <= cfg_pwdata[DELAY_W-1:0];
        REG_MAX:     max_r     <= cfg_pwdata[DELAY_W-1:0];
        REG_GROWTH:  growth_r  <= cfg_pwdata[GROWTH_W-1:0];
        REG_JITTER:  jitter_r  <= cfg_pwdata[JITTER_W-1:0];
        REG_LIMIT:   limit_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INITIAL: cfg_prdata = {{(DATA_W-DELAY_W){1'b0}}, initial_r};
      REG_MAX:     cfg_prdata = {{(DATA_W-DELAY_W){1'b0}}, max_r};
      REG_GROWTH:  cfg_prdata = {{(DATA_W-GROWTH_W){1'b0}}, growth_r};
      REG_JITTER:  cfg_prdata = {{(DATA_W-JITTER_W){1'b0}}, jitter_r};
      REG_LIMIT:   cfg_prdata = limit_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- units
  bkj_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Xorshift of the seed, taken fresh from the stored seed.
  always_comb begin
    hash = seed_r;
    hash = hash ^ {hash[SEED_W-14:0], 13'b0};
    hash = hash ^ {17'b0, hash[SEED_W-1:17]};
    hash = hash ^ {hash[SEED_W-6:0], 5'b0};
  end

  assign span = {jitter_r, 1'b1};

  bkj_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (hash),
    .divisor  (span),
    .done_r   (rem_done),
    .rem_r    (rem_val)
  );

  // ---------------------------------------------------------------- datapath
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;

  // The clamp test d >= floor(max*100/g) is done as (d+1)*g > max*100.
  assign max_x100 = {1'b0, max_r, 6'b0} + {2'b0, max_r, 5'b0} + {5'b0, max_r, 2'b0};
  assign quot     = prod[DIV100_SHIFT+26:DIV100_SHIFT];

  // Jitter factor 100 + offset, where offset = remainder - jitter percent.
  assign fsum       = (SPAN_W+2)'(100) + {2'b0, rem_val};
  assign factor_pos = fsum > {3'b0, jitter_r};
  assign factor     = SPAN_W'(fsum - {3'b0, jitter_r});

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    d_nxt     = d_r;
    step_nxt  = step_r;
    dg_nxt    = dg_r;
    seed_nxt  = seed_r;
    jit_nxt   = jit_r;
    mul_a     = '0;
    mul_b     = '0;
    rem_start = 1'b0;
    ovalid_nxt = ovalid_r & ~out_tready;
    obase_nxt  = obase_r;
    ojit_nxt   = ojit_r;
    odeny_nxt  = odeny_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          seed_nxt = in_tdata;
          step_nxt = '0;
          d_nxt    = initial_r;
          unique case (op_t'(in_tuser))
            OP_QUERY: begin
              d_nxt     = cur_r;
              state_nxt = ST_JSTART;
            end
            OP_FAILURE: begin
              if (count_r != '1) begin
                count_nxt = count_r + 1'b1;
              end
              state_nxt = ST_CHK;
            end
            OP_SUCCESS: begin
              count_nxt = '0;
              state_nxt = ST_CHK;
            end
            OP_RECOMPUTE: state_nxt = ST_CHK;
            default: state_nxt = ST_CHK;
          endcase
        end
      end
      ST_CHK: begin
        if (step_r == count_r) begin
          state_nxt = ST_JSTART;
        end else begin
          mul_a     = {{(MUL_W-DELAY_W-1){1'b0}}, {1'b0, d_r} + 1'b1};
          mul_b     = {{(MUL_W-GROWTH_W){1'b0}}, growth_r};
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        if ((growth_r != '0) && (prod[MUL_W-1:0] > {3'b0, max_x100})) begin
          d_nxt     = max_r;
          state_nxt = ST_JSTART;
        end else begin
          dg_nxt    = prod[MUL_W-1:0] - {{(MUL_W-GROWTH_W){1'b0}}, growth_r};
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        mul_a     = dg_r;
        mul_b     = DIV100_RECIP;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (quot > {5'b0, max_r}) begin
          d_nxt     = max_r;
          state_nxt = ST_JSTART;
        end else if (quot == {5'b0, d_r}) begin
          state_nxt = ST_JSTART;
        end else begin
          d_nxt     = quot[DELAY_W-1:0];
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_JSTART: begin
        cur_nxt = d_r;
        if (jitter_r == '0) begin
          jit_nxt   = d_r;
          state_nxt = ST_OUT;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_JMOD;
        end
      end
      ST_JMOD: begin
        if (rem_done) begin
          if (factor_pos) begin
            mul_a     = {{(MUL_W-DELAY_W){1'b0}}, d_r};
            mul_b     = {{(MUL_W-SPAN_W){1'b0}}, factor};
            state_nxt = ST_JMUL;
          end else begin
            // A non-positive factor floors to 1, then the upper clamp applies.
            jit_nxt   = (max_r == '0) ? '0 : DELAY_W'(1);
            state_nxt = ST_OUT;
          end
        end
      end
      ST_JMUL: begin
        mul_a     = prod[MUL_W-1:0];
        mul_b     = DIV100_RECIP;
        state_nxt = ST_JDIV;
      end
      ST_JDIV: begin
        if (quot > {5'b0, max_r}) begin
          jit_nxt = max_r;
        end else if (quot == '0) begin
          jit_nxt = (max_r == '0) ? '0 : DELAY_W'(1);
        end else begin
          jit_nxt = quot[DELAY_W-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          obase_nxt  = cur_r;
          ojit_nxt   = jit_r;
          odeny_nxt  = (limit_r != '0) && (count_r >= limit_r);
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      cur_r    <= INITIAL_RST;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cur_r    <= cur_nxt;
      ovalid_r <= ovalid_nxt;
    end
    d_r     <= d_nxt;
    step_r  <= step_nxt;
    dg_r    <= dg_nxt;
    seed_r  <= seed_nxt;
    jit_r   <= jit_nxt;
    obase_r <= obase_nxt;
    ojit_r  <= ojit_nxt;
    odeny_r <= odeny_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'b0, odeny_r, ojit_r, obase_r};

endmodule
